/* src/assert_macros.svh */
// ---------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, sampled on i_clk, off during reset
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define MF3_CHECK(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("mf3 same-cycle check failed");

// next-cycle implication
`define MF3_CHECK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("mf3 next-cycle check failed");

`endif

/* src/mf3_pkg.sv */
// ---------------------------------------------------------------------------
// mf3_pkg
// shared types and constants of the 3x3 border-shrinking median filter
// ---------------------------------------------------------------------------
package mf3_pkg;

    localparam int PIX_BITS        = 8;
    localparam int MAX_WIDTH_DEF   = 1024;
    localparam int WIN_SIZE        = 9;
    localparam int CFG_IDX_BITS    = 2;
    localparam int CFG_DATA_BITS   = 12;
    localparam int CFG_W_BITS      = 11;
    localparam int CFG_H_BITS      = 12;
    localparam int ROW_BITS        = CFG_H_BITS + 1;   // counts up to height+1 while draining

    localparam logic [CFG_W_BITS-1:0] WIDTH_RST  = CFG_W_BITS'(640);
    localparam logic [CFG_H_BITS-1:0] HEIGHT_RST = CFG_H_BITS'(480);

    // register indexes on the config port
    localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_WIDTH  = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_HEIGHT = CFG_IDX_BITS'(1);

    // input word commands
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    typedef logic [PIX_BITS-1:0] t_pix;

    // window element r*3+c: row 0 oldest, column 2 newest
    typedef t_pix [WIN_SIZE-1:0] t_win;
    typedef logic [WIN_SIZE-1:0] t_win_mask;

    typedef struct packed {
        logic command;
        t_pix red_value;
    } t_in_item;

    typedef struct packed {
        t_pix median_value;
        logic frame_done;
    } t_out_item;

    // control carried by the input stage register
    typedef struct packed {
        logic      emit;
        logic      frame_done;
        logic      wr_en;
        t_win_mask mask;
    } t_stage_ctl;

endpackage

/* src/mf3_line_buf.sv */
// ---------------------------------------------------------------------------
// mf3_line_buf
// two line stores holding the rows above the incoming one, registered read
// ---------------------------------------------------------------------------
module mf3_line_buf
    import mf3_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rd_en,
    input  logic [$clog2(MAX_WIDTH)-1:0] i_rd_addr,
    input  logic                         i_wr_en,
    input  logic [$clog2(MAX_WIDTH)-1:0] i_wr_addr,
    input  t_pix                         i_wr_pix,
    output t_pix                         o_top,
    output t_pix                         o_mid
);

    t_pix r_upper [MAX_WIDTH];
    t_pix r_middle[MAX_WIDTH];
    t_pix r_top;
    t_pix r_mid;

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_top <= r_upper[i_rd_addr];
            r_mid <= r_middle[i_rd_addr];
        end
    end

    // middle row moves up, new sample becomes the middle row
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_upper[i_wr_addr]  <= r_mid;
            r_middle[i_wr_addr] <= i_wr_pix;
        end
    end

    assign o_top = r_top;
    assign o_mid = r_mid;

endmodule

/* src/mf3_median.sv */
// ---------------------------------------------------------------------------
// mf3_median
// rank-select median over the valid part of a 3x3 window, upper median
// ---------------------------------------------------------------------------
module mf3_median
    import mf3_pkg::*;
(
    input  t_win      i_win,
    input  t_win_mask i_mask,
    output t_pix      o_median
);

    logic [3:0] target;
    logic [3:0] rank [WIN_SIZE];
    t_pix       pick;

    assign target = 4'($countones(i_mask)) >> 1;

    // rank of each element among valid ones, ties broken by position
    always_comb begin
        for (int i = 0; i < WIN_SIZE; i++) begin
            rank[i] = '0;
            for (int j = 0; j < WIN_SIZE; j++) begin
                if (i_mask[j] && ((i_win[j] < i_win[i]) ||
                                  ((i_win[j] == i_win[i]) && (j < i)))) begin
                    rank[i] = rank[i] + 4'd1;
                end
            end
        end
    end

    // exactly one valid element holds the target rank
    always_comb begin
        pick = '0;
        for (int i = 0; i < WIN_SIZE; i++) begin
            if (i_mask[i] && (rank[i] == target)) begin
                pick = pick | i_win[i];
            end
        end
    end

    assign o_median = pick;

endmodule

/* src/median_filter_3x3_edge_shrink_top.sv */
// ---------------------------------------------------------------------------
// median_filter_3x3_edge_shrink_top
// 3x3 median filter over a raster stream with a window clipped at the border
// ---------------------------------------------------------------------------
// Takes one 8-bit sample word per clock in raster order and returns the
// median of each pixel's 3x3 neighbourhood, counting only pixels inside the
// frame (4 at corners, 6 on edges, 9 inside; even counts take the upper
// median). Results lag the input by one row plus one pixel, so after the
// frame's last pixel the user sends width+1 drain words; the result on the
// last drain word carries frame_done. Pixel words arriving after the last
// pixel and drain words arriving before it are swallowed without a result.
// Throughput is one word per clock while results are taken. The line store
// read is registered with the input stage; window update and median feed the
// result register. Writing either config register restarts the frame
// counters but keeps the line stores; write config only while idle. The
// line stores are plain memories with no clearing pass after reset.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module median_filter_3x3_edge_shrink_top
    import mf3_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // config write channel
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    // input word channel
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  t_in_item                 i_in_data,
    // result word channel
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output t_out_item                o_out_data
);

    localparam int AW   = $clog2(MAX_WIDTH);
    localparam int WW   = AW + 1;
    localparam int CMPW = (WW > CFG_W_BITS) ? WW : CFG_W_BITS;

    // config registers
    logic [CFG_W_BITS-1:0] r_cfg_width;
    logic [CFG_H_BITS-1:0] r_cfg_height;

    // raster position of the next input word
    logic [AW-1:0]       r_col, n_col;
    logic [ROW_BITS-1:0] r_row, n_row;

    // input stage register
    logic          r_a_valid;
    t_stage_ctl    r_a_ctl;
    logic [AW-1:0] r_a_addr;
    t_pix          r_a_bot;

    // window and result register
    t_win      r_win, n_win;
    logic      r_out_valid;
    t_out_item r_out;

    logic                cfg_wr;
    logic [CMPW-1:0]     w_raw, w_eff, col_inc;
    logic [CFG_H_BITS-1:0] h_eff;
    logic [ROW_BITS-1:0] h_ext;
    logic                r_lt_h, r_gt_h, col_wrap;
    logic                act_cond, accept, act;
    logic                start_row, norm_emit;
    logic [2:0]          row_ok, col_ok;
    t_stage_ctl          ctl;
    logic                out_free, a_adv;
    t_pix                lb_top, lb_mid, med;

    // ---- configuration ------------------------------------------------------
    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= WIDTH_RST;
            r_cfg_height <= HEIGHT_RST;
        end else if (cfg_wr) begin
            if (i_cfg_index == REG_IMAGE_WIDTH) begin
                r_cfg_width <= i_cfg_data[CFG_W_BITS-1:0];
            end
            if (i_cfg_index == REG_IMAGE_HEIGHT) begin
                r_cfg_height <= i_cfg_data[CFG_H_BITS-1:0];
            end
        end
    end

    // width clipped to 2..MAX_WIDTH, height to at least 2
    assign w_raw = CMPW'(r_cfg_width);
    always_comb begin
        priority if (w_raw < CMPW'(2)) begin
            w_eff = CMPW'(2);
        end else if (w_raw > CMPW'(MAX_WIDTH)) begin
            w_eff = CMPW'(MAX_WIDTH);
        end else begin
            w_eff = w_raw;
        end
    end
    assign h_eff = (r_cfg_height < CFG_H_BITS'(2)) ? CFG_H_BITS'(2) : r_cfg_height;
    assign h_ext = ROW_BITS'(h_eff);

    // ---- word classification --------------------------------------------------
    assign r_lt_h   = r_row < h_ext;
    assign r_gt_h   = r_row > h_ext;
    assign act_cond = (i_in_data.command == CMD_PIXEL) ? r_lt_h : !r_lt_h;

    // handshake: stage advances unless its result finds no free slot
    assign out_free   = !r_out_valid || i_out_ready;
    assign a_adv      = r_a_valid && (!r_a_ctl.emit || out_free);
    assign o_in_ready = !r_a_valid || a_adv;
    assign accept     = i_in_valid && o_in_ready;
    assign act        = accept && act_cond;

    // first column of a row finishes the last pixel of the row two above;
    // the window then shifts, so that pixel's columns sit at 0..1
    assign start_row = (r_col == '0) && (r_row >= ROW_BITS'(2));
    assign norm_emit = (r_col != '0) && (r_row != '0);

    always_comb begin
        if (start_row) begin
            row_ok = {!r_gt_h, 1'b1, r_row >= ROW_BITS'(3)};
            col_ok = 3'b011;
        end else begin
            row_ok = {r_lt_h, 1'b1, r_row >= ROW_BITS'(2)};
            col_ok = {1'b1, 1'b1, r_col >= AW'(2)};
        end
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                ctl.mask[r*3+c] = row_ok[r] && col_ok[c];
            end
        end
        ctl.emit       = start_row || norm_emit;
        ctl.frame_done = r_gt_h;
        ctl.wr_en      = r_lt_h;
    end

    // ---- raster counters --------------------------------------------------------
    assign col_inc  = CMPW'(r_col) + CMPW'(1);
    assign col_wrap = col_inc >= w_eff;

    // only a write to a mapped register restarts the frame
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (cfg_wr && (i_cfg_index == REG_IMAGE_WIDTH ||
                       i_cfg_index == REG_IMAGE_HEIGHT)) begin
            n_col = '0;
            n_row = '0;
        end else if (act) begin
            priority if (r_gt_h) begin
                n_col = '0;
                n_row = '0;
            end else if (col_wrap) begin
                n_col = '0;
                n_row = r_row + ROW_BITS'(1);
            end else begin
                n_col = col_inc[AW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // ---- input stage ------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (act) begin
            r_a_valid <= 1'b1;
        end else if (a_adv) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (act) begin
            r_a_ctl  <= ctl;
            r_a_addr <= r_col;
            r_a_bot  <= r_lt_h ? i_in_data.red_value : '0;
        end
    end

    // line stores read on unswallowed words, written as pixel words move on
    mf3_line_buf #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_buf (
        .i_clk     (i_clk),
        .i_rd_en   (act),
        .i_rd_addr (r_col),
        .i_wr_en   (a_adv && r_a_ctl.wr_en),
        .i_wr_addr (r_a_addr),
        .i_wr_pix  (r_a_bot),
        .o_top     (lb_top),
        .o_mid     (lb_mid)
    );

    // ---- window shift and median ------------------------------------------------
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            n_win[r*3]   = r_win[r*3+1];
            n_win[r*3+1] = r_win[r*3+2];
        end
        n_win[2] = lb_top;
        n_win[5] = lb_mid;
        n_win[8] = r_a_bot;
    end

    mf3_median u_median (
        .i_win    (n_win),
        .i_mask   (r_a_ctl.mask),
        .o_median (med)
    );

    always_ff @(posedge i_clk) begin
        if (a_adv) begin
            r_win <= n_win;
        end
    end

    // ---- result register ----------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (a_adv && r_a_ctl.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_adv && r_a_ctl.emit) begin
            r_out.median_value <= med;
            r_out.frame_done   <= r_a_ctl.frame_done;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // ---- checks -----------------------------------------------------------------
    `MF3_CHECK(a_stall_only_when_full, !o_in_ready, r_a_valid)
    `MF3_CHECK(a_row_bounded, 1'b1, r_row <= (h_ext + ROW_BITS'(1)))
    `MF3_CHECK_NEXT(a_frame_end_clears, act && r_gt_h, (r_row == '0) && (r_col == '0))

endmodule
